>>> src/pspac_pkg.sv
// Shared types, constants and codes for the per-peer sequenced ack channel.
package pspac_pkg;

  localparam int MAX_PEERS   = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int SEQ_BITS    = 32;

  localparam int PIDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int NP_W   = $clog2(MAX_PEERS + 1);
  localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = ((MAX_PEERS * QUEUE_DEPTH) > 1) ?
                          $clog2(MAX_PEERS * QUEUE_DEPTH) : 1;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_ACK  = 2'd1,
    OP_DATA = 2'd2,
    OP_EXT  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    RK_RESEND  = 2'd0,
    RK_ACK     = 2'd1,
    RK_DELIVER = 2'd2,
    RK_REFUSED = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    SRC_REFUSE,
    SRC_RESEND,
    SRC_ACK,
    SRC_DELIVER,
    SRC_DIRECT
  } out_src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEND,
    ST_SCAN_OUT,
    ST_ACK_RD,
    ST_ACK_CHK,
    ST_DATA_ACK,
    ST_DATA_DLV,
    ST_DIRECT
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  peer;
    logic [31:0] seq_in;
    logic [15:0] payload_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [2:0]  peer_out;
    logic [31:0] seq_out;
    logic [15:0] payload_out;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic     load_in;
    logic     sel_scan;
    logic     mem_rd;
    logic     q_push;
    logic     q_pop;
    logic     exp_inc;
    logic     scan_inc;
    logic     emit;
    logic     emit_last;
    out_src_t src;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       is_peer;
    logic       q_full;
    logic       q_nonempty;
    logic       scan_nonempty;
    logic       scan_more;
    logic       scan_done;
    logic       head_match;
    logic       exp_match;
    logic       out_free;
  } sts_t;

endpackage

>>> src/pspac_ctrl.sv
// Controller state machine: sequences send, resend scan, ack and delivery steps.
module pspac_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  pspac_pkg::sts_t sts,
  output pspac_pkg::cmd_t cmd,
  output logic            idle
);
  import pspac_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.src    = SRC_REFUSE;
    state_next = state;
    idle       = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.sel_scan = 1'b1;
        if (sts.op == OP_SEND) begin
          state_next = ST_SEND;
        end else if (sts.scan_done) begin
          if (sts.op == OP_EXT || !sts.is_peer) begin
            state_next = ST_DIRECT;
          end else if (sts.op == OP_ACK) begin
            state_next = ST_ACK_RD;
          end else begin
            state_next = ST_DATA_ACK;
          end
        end else if (sts.scan_nonempty) begin
          cmd.mem_rd = 1'b1;
          state_next = ST_SCAN_OUT;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      ST_SEND: begin
        if (!sts.is_peer || sts.q_full) begin
          if (sts.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            cmd.src       = SRC_REFUSE;
            state_next    = ST_IDLE;
          end
        end else begin
          cmd.q_push = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN_OUT: begin
        cmd.sel_scan = 1'b1;
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.src       = SRC_RESEND;
          // last only when nothing follows: an ack from a peer with no later resend
          cmd.emit_last = (sts.op == OP_ACK) && sts.is_peer && !sts.scan_more;
          cmd.scan_inc  = 1'b1;
          state_next    = ST_SCAN;
        end
      end
      ST_ACK_RD: begin
        if (sts.q_nonempty) begin
          cmd.mem_rd = 1'b1;
          state_next = ST_ACK_CHK;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_ACK_CHK: begin
        cmd.q_pop  = sts.head_match;
        state_next = ST_IDLE;
      end
      ST_DATA_ACK: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.src       = SRC_ACK;
          cmd.emit_last = !sts.exp_match;
          state_next    = sts.exp_match ? ST_DATA_DLV : ST_IDLE;
        end
      end
      ST_DATA_DLV: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.src       = SRC_DELIVER;
          cmd.emit_last = 1'b1;
          cmd.exp_inc   = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_DIRECT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.src       = SRC_DIRECT;
          cmd.emit_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/pspac_dp.sv
// Datapath: peer state, queue memory, request latch, scan index and result register.
module pspac_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [3:0]           cfg_wdata,
  input  pspac_pkg::in_item_t  req_item,
  input  pspac_pkg::cmd_t      cmd,
  output pspac_pkg::sts_t      sts,
  output logic                 res_valid,
  input  logic                 res_stall,
  output pspac_pkg::out_item_t res_item
);
  import pspac_pkg::*;

  typedef struct packed {
    logic [SEQ_BITS-1:0] seq;
    logic [15:0]         pay;
  } entry_t;

  logic [3:0]          active_peers;
  logic [NP_W-1:0]     n_peers;

  logic [1:0]          op_q;
  logic [2:0]          peer_q;
  logic [SEQ_BITS-1:0] seq_q;
  logic [15:0]         pay_q;
  logic [NP_W-1:0]     scan_idx;

  logic [SEQ_BITS-1:0] next_seq [MAX_PEERS];
  logic [SEQ_BITS-1:0] exp_seq  [MAX_PEERS];
  logic [HEAD_W-1:0]   head     [MAX_PEERS];
  logic [CNT_W-1:0]    count    [MAX_PEERS];

  entry_t              qmem [MAX_PEERS * QUEUE_DEPTH];
  entry_t              rd_data;

  logic [MAX_PEERS-1:0] nonempty;
  logic [MAX_PEERS-1:0] full;
  logic                 is_peer;
  logic                 scan_more;
  logic                 out_free;
  logic [PIDX_W-1:0]    p_idx;
  logic [PIDX_W-1:0]    s_idx;
  logic [PIDX_W-1:0]    idx;
  logic [ADDR_W-1:0]    rd_addr;
  logic [ADDR_W-1:0]    wr_addr;
  logic [CNT_W:0]       slot_sum;
  logic [HEAD_W-1:0]    slot;
  logic [HEAD_W-1:0]    head_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_peers <= 4'(MAX_PEERS);
    end else if (cfg_we) begin
      active_peers <= cfg_wdata;
    end
  end

  always_comb begin
    if (active_peers == 4'd0) begin
      n_peers = NP_W'(1);
    end else if ({1'b0, active_peers} > 5'(MAX_PEERS)) begin
      n_peers = NP_W'(MAX_PEERS);
    end else begin
      n_peers = NP_W'(active_peers);
    end
  end

  assign p_idx   = PIDX_W'(peer_q);
  assign s_idx   = scan_idx[PIDX_W-1:0];
  assign idx     = cmd.sel_scan ? s_idx : p_idx;
  assign is_peer = ({1'b0, peer_q} < 4'(n_peers));

  always_comb begin
    scan_more = 1'b0;
    for (int k = 0; k < MAX_PEERS; k++) begin
      nonempty[k] = (count[k] != '0);
      full[k]     = (count[k] >= CNT_W'(QUEUE_DEPTH));
      if (nonempty[k] && (NP_W'(k) > scan_idx) && (NP_W'(k) < n_peers)) begin
        scan_more = 1'b1;
      end
    end
  end

  // Ring slot of the tail: head plus count, wrapped once; also the head's next slot.
  always_comb begin
    slot_sum = (CNT_W + 1)'(head[p_idx]) + (CNT_W + 1)'(count[p_idx]);
    if (slot_sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      slot = HEAD_W'(slot_sum - (CNT_W + 1)'(QUEUE_DEPTH));
    end else begin
      slot = HEAD_W'(slot_sum);
    end
    if (head[p_idx] == HEAD_W'(QUEUE_DEPTH - 1)) begin
      head_next = '0;
    end else begin
      head_next = head[p_idx] + HEAD_W'(1);
    end
  end

  assign rd_addr = ADDR_W'(idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head[idx]);
  assign wr_addr = ADDR_W'(p_idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);

  always_ff @(posedge clk) begin
    if (cmd.q_push) begin
      qmem[wr_addr] <= '{seq: next_seq[p_idx], pay: pay_q};
    end
    if (cmd.mem_rd) begin
      rd_data <= qmem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q   <= req_item.opcode;
      peer_q <= req_item.peer;
      seq_q  <= SEQ_BITS'(req_item.seq_in);
      pay_q  <= req_item.payload_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      for (int k = 0; k < MAX_PEERS; k++) begin
        next_seq[k] <= '0;
        exp_seq[k]  <= '0;
        head[k]     <= '0;
        count[k]    <= '0;
      end
    end else begin
      if (cmd.load_in) begin
        scan_idx <= '0;
      end else if (cmd.scan_inc) begin
        scan_idx <= scan_idx + NP_W'(1);
      end
      if (cmd.q_push) begin
        count[p_idx]    <= count[p_idx] + CNT_W'(1);
        next_seq[p_idx] <= next_seq[p_idx] + SEQ_BITS'(1);
      end
      if (cmd.q_pop) begin
        count[p_idx] <= count[p_idx] - CNT_W'(1);
        head[p_idx]  <= head_next;
      end
      if (cmd.exp_inc) begin
        exp_seq[p_idx] <= exp_seq[p_idx] + SEQ_BITS'(1);
      end
    end
  end

  assign out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_item.last <= cmd.emit_last;
      case (cmd.src)
        SRC_REFUSE: begin
          res_item.result_kind <= RK_REFUSED;
          res_item.peer_out    <= peer_q;
          res_item.seq_out     <= is_peer ? 32'(next_seq[p_idx]) : 32'd0;
          res_item.payload_out <= pay_q;
        end
        SRC_RESEND: begin
          res_item.result_kind <= RK_RESEND;
          res_item.peer_out    <= 3'(s_idx);
          res_item.seq_out     <= 32'(rd_data.seq);
          res_item.payload_out <= rd_data.pay;
        end
        SRC_ACK: begin
          res_item.result_kind <= RK_ACK;
          res_item.peer_out    <= peer_q;
          res_item.seq_out     <= 32'(seq_q);
          res_item.payload_out <= 16'd0;
        end
        SRC_DELIVER: begin
          res_item.result_kind <= RK_DELIVER;
          res_item.peer_out    <= peer_q;
          res_item.seq_out     <= 32'(seq_q);
          res_item.payload_out <= pay_q;
        end
        default: begin
          res_item.result_kind <= RK_DELIVER;
          res_item.peer_out    <= 3'd0;
          res_item.seq_out     <= 32'd0;
          res_item.payload_out <= pay_q;
        end
      endcase
    end
  end

  always_comb begin
    sts.op            = op_q;
    sts.is_peer       = is_peer;
    sts.q_full        = full[p_idx];
    sts.q_nonempty    = nonempty[p_idx];
    sts.scan_nonempty = nonempty[s_idx];
    sts.scan_more     = scan_more;
    sts.scan_done     = (scan_idx >= n_peers);
    sts.head_match    = (rd_data.seq == seq_q);
    sts.exp_match     = (exp_seq[p_idx] == seq_q);
    sts.out_free      = out_free;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result register loaded while a stalled result is held");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.q_push |-> (is_peer && !full[p_idx]))
    else $error("push into a full or inactive queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.q_pop |-> nonempty[p_idx])
    else $error("pop from an empty queue");

  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_rd |-> nonempty[idx])
    else $error("queue head read from an empty queue");

  a_pop_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.q_pop |-> $past(cmd.mem_rd))
    else $error("pop without a fresh head read");

endmodule

>>> src/per_peer_sequenced_ack_channel.sv
// Top level of the per-peer sequenced ack channel: controller plus datapath.
//
//   channel   signals                          direction
//   request   req_valid, req_stall, req_item   in  (opcode, peer, seq_in, payload_in)
//   result    res_valid, res_stall, res_item   out (kind, peer, seq, payload, last)
//   config    cfg_we, cfg_wdata                in  (active_peers)
//
// A send passes through the scan and send states. A receive scans each active peer,
// reads the head and emits a resend for each non-empty queue, then does the ack
// check, the ack and delivery, or a direct delivery; the scan covers active peers only.
// Synchronous reset clears all sequence counters, heads and counts at once.
// A held result (res_stall) pauses the controller at its next emit step.
module per_peer_sequenced_ack_channel (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [3:0]           cfg_wdata,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  pspac_pkg::in_item_t  req_item,
  output logic                 res_valid,
  input  logic                 res_stall,
  output pspac_pkg::out_item_t res_item
);
  import pspac_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic idle;

  assign req_stall = !idle;

  pspac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .sts       (sts),
    .cmd       (cmd),
    .idle      (idle)
  );

  pspac_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_item  (req_item),
    .cmd       (cmd),
    .sts       (sts),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

>>> tb/ack_channel_checker.sv
// Checker for the per-peer sequenced ack channel: predicts results and compares them.
module ack_channel_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [3:0]           cfg_wdata,
  input  logic                 req_valid,
  input  logic                 req_stall,
  input  pspac_pkg::in_item_t  req_item,
  input  logic                 res_valid,
  input  logic                 res_stall,
  input  pspac_pkg::out_item_t res_item,
  output int                   outstanding,
  output int                   fails
);
  timeunit 1ns;
  timeprecision 1ps;
  import pspac_pkg::*;

  logic [3:0]        peers_cfg;
  logic [31:0]       tx_seq    [MAX_PEERS];
  logic [31:0]       rx_seq    [MAX_PEERS];
  logic [31:0]       slot_seq  [MAX_PEERS][QUEUE_DEPTH];
  logic [15:0]       slot_pay  [MAX_PEERS][QUEUE_DEPTH];
  logic [HEAD_W-1:0] q_head    [MAX_PEERS];
  logic [CNT_W-1:0]  q_count   [MAX_PEERS];
  out_item_t         pending_results [$];
  int                errors = 0;

  assign fails = errors;

  function automatic out_item_t make_result(kind_t kind, int peer, logic [31:0] seq,
                                            logic [15:0] pay);
    out_item_t r;
    r.result_kind = kind;
    r.peer_out    = 3'(peer);
    r.seq_out     = seq;
    r.payload_out = pay;
    r.last        = 1'b0;
    return r;
  endfunction

  task automatic clear_channels();
    peers_cfg = 4'd8;
    for (int i = 0; i < MAX_PEERS; i++) begin
      tx_seq[i]  = '0;
      rx_seq[i]  = '0;
      q_head[i]  = '0;
      q_count[i] = '0;
    end
    pending_results.delete();
  endtask

  // Work out every result one request causes and queue them in order.
  task automatic predict_request(input in_item_t r);
    out_item_t batch [$];
    opcode_t   op;
    int        n;
    int        p;
    int        slot;
    logic      is_peer;
    op = opcode_t'(r.opcode);
    p  = r.peer;
    n  = (peers_cfg == 0) ? 1 : (peers_cfg > MAX_PEERS) ? MAX_PEERS : int'(peers_cfg);
    is_peer = (p < n);
    if (op == OP_SEND) begin
      if (!is_peer) begin
        batch.push_back(make_result(RK_REFUSED, p, '0, r.payload_in));
      end else if (q_count[p] >= QUEUE_DEPTH) begin
        // full queue: refuse without consuming the sequence number
        batch.push_back(make_result(RK_REFUSED, p, tx_seq[p], r.payload_in));
      end else begin
        slot = (q_head[p] + q_count[p]) % QUEUE_DEPTH;
        slot_seq[p][slot] = tx_seq[p];
        slot_pay[p][slot] = r.payload_in;
        q_count[p] = q_count[p] + 1;
        tx_seq[p]  = tx_seq[p] + 1;
      end
    end else begin
      for (int i = 0; i < n; i++) begin
        if (q_count[i] != 0) begin
          batch.push_back(make_result(RK_RESEND, i, slot_seq[i][q_head[i]],
                                      slot_pay[i][q_head[i]]));
        end
      end
      if (op == OP_EXT || !is_peer) begin
        batch.push_back(make_result(RK_DELIVER, 0, '0, r.payload_in));
      end else if (op == OP_ACK) begin
        if (q_count[p] != 0 && slot_seq[p][q_head[p]] == r.seq_in) begin
          q_head[p]  = HEAD_W'((q_head[p] + 1) % QUEUE_DEPTH);
          q_count[p] = q_count[p] - 1;
        end
      end else begin
        batch.push_back(make_result(RK_ACK, p, r.seq_in, '0));
        if (rx_seq[p] == r.seq_in) begin
          rx_seq[p] = rx_seq[p] + 1;
          batch.push_back(make_result(RK_DELIVER, p, r.seq_in, r.payload_in));
        end
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) pending_results.push_back(batch[i]);
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      clear_channels();
    end else begin
      if (cfg_we) peers_cfg = cfg_wdata;
      // compare before predicting: a result never belongs to a request of this edge
      if (res_valid && !res_stall) begin
        if (pending_results.size() == 0) begin
          $display({"%0t: unexpected result, expected none, ",
                    "got kind %0d peer %0d seq %h pay %h last %0d"},
                   $time, res_item.result_kind, res_item.peer_out, res_item.seq_out,
                   res_item.payload_out, res_item.last);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("result_kind", 32'(want.result_kind), 32'(res_item.result_kind));
          check_field("peer_out", 32'(want.peer_out), 32'(res_item.peer_out));
          check_field("seq_out", want.seq_out, res_item.seq_out);
          check_field("payload_out", 32'(want.payload_out), 32'(res_item.payload_out));
          check_field("last", 32'(want.last), 32'(res_item.last));
        end
      end
      if (req_valid && !req_stall) predict_request(req_item);
    end
    outstanding <= pending_results.size();
  end

endmodule

>>> tb/tb_top.sv
// Top of the per-peer sequenced ack channel testbench: clock, reset, stimulus, verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pspac_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [3:0] cfg_wdata = '0;
  logic       req_valid = 1'b0;
  logic       req_stall;
  in_item_t   req_item = '0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  out_item_t  res_item;
  int         outstanding;
  int         fails;

  // stimulus steering: what the channel should hold, so acks and data can hit
  int          live_peers = MAX_PEERS;
  logic [31:0] sent_next  [MAX_PEERS] = '{default: '0};
  logic [31:0] acked_next [MAX_PEERS] = '{default: '0};
  logic [31:0] recv_next  [MAX_PEERS] = '{default: '0};
  bit          calm = 1'b0;
  int          hold_requests = 0;

  per_peer_sequenced_ack_channel dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  ack_channel_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_item    (req_item),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res_item    (res_item),
    .outstanding (outstanding),
    .fails       (fails)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic issue(opcode_t op, int peer, logic [31:0] seq, logic [15:0] pay);
    in_item_t it;
    it.opcode     = op;
    it.peer       = 3'(peer);
    it.seq_in     = seq;
    it.payload_in = pay;
    if (!calm && $urandom_range(99) < 20) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= it;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (peer < live_peers) begin
      case (op)
        OP_SEND: if (sent_next[peer] - acked_next[peer] < QUEUE_DEPTH) sent_next[peer] += 1;
        OP_ACK:  if (sent_next[peer] != acked_next[peer] && seq == acked_next[peer])
                   acked_next[peer] += 1;
        OP_DATA: if (seq == recv_next[peer]) recv_next[peer] += 1;
        default: ;
      endcase
    end
  endtask

  // Hold until every expected result is back, then let the block settle.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_peers(logic [3:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    live_peers = (v == 0) ? 1 : (v > MAX_PEERS) ? MAX_PEERS : int'(v);
  endtask

  task automatic random_request(int send_pct);
    int          pick;
    int          p;
    logic [31:0] s;
    pick = $urandom_range(99);
    p = ($urandom_range(99) < 85) ? $urandom_range(live_peers - 1) : $urandom_range(7);
    if (pick < send_pct) begin
      issue(OP_SEND, p, $urandom, 16'($urandom));
    end else if (pick < send_pct + 25) begin
      s = ($urandom_range(9) < 7) ? acked_next[p] :
          ($urandom_range(1) != 0) ? acked_next[p] + 1 : $urandom;
      issue(OP_ACK, p, s, 16'($urandom));
    end else if (pick < send_pct + 50) begin
      s = ($urandom_range(9) < 6) ? recv_next[p] :
          ($urandom_range(1) != 0) ? recv_next[p] - 1 : $urandom;
      issue(OP_DATA, p, s, 16'($urandom));
    end else if (pick < 93) begin
      issue(OP_EXT, $urandom_range(7), $urandom, 16'($urandom));
    end else begin
      // noise: every field random
      issue(opcode_t'($urandom_range(3)), $urandom_range(7), $urandom, 16'($urandom));
    end
  endtask

  task automatic run_phase(logic [3:0] peers, int items, int send_pct, bit hold_rx);
    drain();
    write_peers(peers);
    if (hold_rx) hold_requests++;
    repeat (items) random_request(send_pct);
  endtask

  // Result side: random stalls, a calm stretch, and one long hold-off.
  initial begin
    int holds_served;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_stall <= 1'b0;
      end else begin
        res_stall <= !calm && ($urandom_range(99) < 20);
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("per_peer_sequenced_ack_channel regression: fail");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // above the peer count: acts as all peers
    write_peers(4'd15);

    issue(OP_EXT, 7, 32'hffff_ffff, 16'hffff);
    issue(OP_ACK, 0, 32'h0, 16'h0);           // empty queue: ignored
    issue(OP_DATA, 0, 32'h0, 16'h0);          // in order: ack and deliver
    issue(OP_DATA, 0, 32'h0, 16'h1234);       // duplicate: ack only
    issue(OP_DATA, 7, 32'hffff_ffff, 16'haaaa);
    // fill one queue past its depth: the last send is refused
    for (int i = 0; i <= QUEUE_DEPTH; i++) begin
      issue(OP_SEND, 3, (i == 0) ? 32'hffff_ffff : 32'h0,
            (i == 0) ? 16'hffff : 16'(i * 3001));
    end
    issue(OP_DATA, 2, 32'h0, 16'h5555);       // resend head, ack, deliver
    issue(OP_ACK, 3, 32'd7, 16'h0);           // wrong sequence: resend only
    issue(OP_ACK, 3, 32'd0, 16'h0);           // frees the head

    run_phase(4'd0, 50, 45, 1'b0);
    calm = 1'b1;
    run_phase(4'd8, 50, 35, 1'b0);
    calm = 1'b0;
    run_phase(4'd1, 50, 35, 1'b0);
    run_phase(4'd9, 50, 25, 1'b1);
    run_phase(4'($urandom_range(2, 7)), 50, 35, 1'b0);
    run_phase(4'd4, 50, 40, 1'b0);
    run_phase(4'd15, 50, 30, 1'b0);
    drain();

    if (fails == 0) begin
      $display("per_peer_sequenced_ack_channel regression: pass");
    end else begin
      $display("per_peer_sequenced_ack_channel regression: fail");
    end
    $finish;
  end

endmodule
